### src/ntw_pkg.sv
// Shared types and constants for the name tally block.
package ntw_pkg;

  localparam int NAME_BYTES = 20;
  localparam int LOW_BITS   = 64;
  localparam int MID_BITS   = 64;
  localparam int HIGH_BITS  = 32;
  localparam int NAME_BITS  = LOW_BITS + MID_BITS + HIGH_BITS;

  // Byte k of the name sits in bits 8k+7..8k: low field first, high field last.
  typedef logic [NAME_BITS-1:0] name_t;

endpackage

### src/ntw_name_if.sv
// Valid/ready channel that carries one 20-byte name per item.
interface ntw_name_if
  import ntw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [LOW_BITS-1:0]  name_bytes_low;
  logic [MID_BITS-1:0]  name_bytes_mid;
  logic [HIGH_BITS-1:0] name_bytes_high;

  modport source (output valid, output name_bytes_low, output name_bytes_mid,
                  output name_bytes_high, input ready);
  modport sink   (input valid, input name_bytes_low, input name_bytes_mid,
                  input name_bytes_high, output ready);
endinterface

### src/ntw_result_if.sv
// Valid/ready channel that carries one tally result per item.
interface ntw_result_if
  import ntw_pkg::*;
#(
  parameter int COUNT_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] count_for_name;
  logic                  was_new;
  logic                  table_full;
  logic [COUNT_BITS-1:0] winner_count;
  logic [LOW_BITS-1:0]   winner_low;
  logic [MID_BITS-1:0]   winner_mid;
  logic [HIGH_BITS-1:0]  winner_high;

  modport source (output valid, output count_for_name, output was_new, output table_full,
                  output winner_count, output winner_low, output winner_mid,
                  output winner_high, input ready);
  modport sink   (input valid, input count_for_name, input was_new, input table_full,
                  input winner_count, input winner_low, input winner_mid,
                  input winner_high, output ready);
endinterface

### src/name_tally_with_winner_top.sv
// Name tally with running winner: table memory, sequential search and update.
//
// Each item carries a 20-byte name; bytes after the first zero byte are
// treated as zero. The name is searched entry by entry in a table memory
// (one read per cycle, registered read, one write port) holding the distinct
// names in insertion order with their counts. Each used entry is read in
// turn and compared with the name; on a match, or after the last used entry,
// an update state registers the result and the block returns to idle for the
// next item. The update waits while the output register holds an untaken
// result. The block takes one item at a time; a finished result waits in an
// output register while the next item is searched. A known name's count
// saturates at all ones; a new name that finds the table full is dropped and
// flagged. The winner is the highest count, the earliest entry on ties. The
// table needs no clearing after reset.
module name_tally_with_winner_top
  import ntw_pkg::*;
#(
  parameter int MAX_NAMES  = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  ntw_name_if.sink     names,
  ntw_result_if.source results
);

  localparam int IDXW    = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
  localparam int ENTRY_W = NAME_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [IDXW:0]         USED_MAX = (IDXW+1)'(MAX_NAMES);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  function automatic name_t canon_name(input name_t raw);
    name_t res;
    logic  ended;
    res   = '0;
    ended = 1'b0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (!ended) res[8*k +: 8] = raw[8*k +: 8];
      if (raw[8*k +: 8] == 8'd0) ended = 1'b1;
    end
    return res;
  endfunction

  state_t state;

  logic [ENTRY_W-1:0] table_mem [MAX_NAMES];
  logic [ENTRY_W-1:0] rd_data;

  name_t                 name_q;
  logic [IDXW:0]         used;
  logic [IDXW:0]         scan_idx;
  logic                  cmp_valid;
  logic [IDXW-1:0]       cmp_idx;
  logic                  hit;
  logic [IDXW-1:0]       hit_idx;
  logic [COUNT_BITS-1:0] hit_count;

  logic [COUNT_BITS-1:0] best_count;
  logic [IDXW-1:0]       best_index;
  name_t                 best_name;

  logic                  out_valid;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_new;
  logic                  out_full;
  logic [COUNT_BITS-1:0] out_wcount;
  name_t                 out_wname;

  name_t                 rd_name;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  match;
  logic                  scan_more;
  logic                  rd_en;
  logic                  out_free;
  logic                  is_full;
  logic [IDXW-1:0]       cand_idx;
  logic [COUNT_BITS-1:0] new_count;
  logic                  take_best;
  logic                  wr_en;

  always_comb begin
    rd_name   = rd_data[NAME_BITS-1:0];
    rd_count  = rd_data[ENTRY_W-1:NAME_BITS];
    match     = cmp_valid && (rd_name == name_q);
    scan_more = scan_idx < used;
    rd_en     = (state == ST_SEARCH) && !match && scan_more;
    out_free  = !out_valid || results.ready;
    is_full   = !hit && (used == USED_MAX);
    cand_idx  = hit ? hit_idx : used[IDXW-1:0];
    if (!hit) begin
      new_count = COUNT_BITS'(1);
    end else if (hit_count == CNT_MAX) begin
      new_count = hit_count;
    end else begin
      new_count = hit_count + COUNT_BITS'(1);
    end
    take_best = !is_full && ((new_count > best_count) ||
                             ((new_count == best_count) && (cand_idx < best_index)));
    wr_en     = (state == ST_UPDATE) && out_free && !is_full;
  end

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) table_mem[cand_idx] <= {new_count, name_q};
    if (rd_en) rd_data <= table_mem[scan_idx[IDXW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      scan_idx   <= '0;
      cmp_valid  <= 1'b0;
      hit        <= 1'b0;
      best_count <= '0;
      best_index <= '0;
      best_name  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == ST_UPDATE) && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (names.valid) begin
            name_q    <= canon_name({names.name_bytes_high, names.name_bytes_mid,
                                     names.name_bytes_low});
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            state     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // Reads are issued one per cycle; each entry is compared in the cycle after its read.
          priority if (match) begin
            hit       <= 1'b1;
            hit_idx   <= cmp_idx;
            hit_count <= rd_count;
            cmp_valid <= 1'b0;
            state     <= ST_UPDATE;
          end else if (scan_more) begin
            cmp_valid <= 1'b1;
            cmp_idx   <= scan_idx[IDXW-1:0];
            scan_idx  <= scan_idx + (IDXW+1)'(1);
          end else begin
            hit       <= 1'b0;
            cmp_valid <= 1'b0;
            state     <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            out_count  <= is_full ? '0 : new_count;
            out_new    <= !hit && !is_full;
            out_full   <= is_full;
            out_wcount <= take_best ? new_count : best_count;
            out_wname  <= take_best ? name_q : best_name;
            if (!hit && !is_full) used <= used + (IDXW+1)'(1);
            if (take_best) begin
              best_count <= new_count;
              best_index <= cand_idx;
              best_name  <= name_q;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign names.ready            = (state == ST_IDLE);
  assign results.valid          = out_valid;
  assign results.count_for_name = out_count;
  assign results.was_new        = out_new;
  assign results.table_full     = out_full;
  assign results.winner_count   = out_wcount;
  assign results.winner_low     = out_wname[LOW_BITS-1:0];
  assign results.winner_mid     = out_wname[LOW_BITS+MID_BITS-1:LOW_BITS];
  assign results.winner_high    = out_wname[NAME_BITS-1:LOW_BITS+MID_BITS];

  a_accept_starts_search: assert property (@(posedge clk) disable iff (rst)
    names.valid && names.ready |=> state == ST_SEARCH)
    else $error("accepted item did not start a search");

  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> best_count >= $past(best_count))
    else $error("winner count decreased");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    (used <= USED_MAX) && (scan_idx <= used))
    else $error("table fill or scan index out of range");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_full ? (out_count == '0 && !out_new)
                            : (out_count != '0 && (!out_new || out_count == 1) &&
                               out_wcount >= out_count)))
    else $error("inconsistent result flags");

endmodule

### sim/testbench.sv
// Self-checking testbench for the name tally block: directed rows and random names.
`timescale 1ns / 1ps

module testbench
  import ntw_pkg::*;
();

  localparam int TABLE_DEPTH = 64;
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [63:0] ONES64 = '1;
  localparam int DIR_ROWS = 17;
  localparam int POOL = 100;
  localparam int RANDOM_ITEMS = 1030;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL = 2 * (TABLE_DEPTH + 3);
  localparam int STUCK_LIMIT = 4000;

  typedef struct packed {
    logic [CNT_W-1:0]     count_for_name;
    logic                 was_new;
    logic                 table_full;
    logic [CNT_W-1:0]     winner_count;
    logic [LOW_BITS-1:0]  winner_low;
    logic [MID_BITS-1:0]  winner_mid;
    logic [HIGH_BITS-1:0] winner_high;
  } tally_t;

  typedef struct {
    name_t  raw;
    bit     typed;
    tally_t want;
  } row_t;

  logic clk;
  logic rst;

  ntw_name_if names_ch ();
  ntw_result_if #(.COUNT_BITS(CNT_W)) results_ch ();

  name_tally_with_winner_top #(
    .MAX_NAMES  (TABLE_DEPTH),
    .COUNT_BITS (CNT_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .names   (names_ch),
    .results (results_ch)
  );

  // Tally state as the block should hold it.
  name_t            tab_name [TABLE_DEPTH];
  logic [CNT_W-1:0] tab_count [TABLE_DEPTH];
  int               tab_used = 0;
  logic [CNT_W-1:0] lead_count = '0;
  int               lead_idx = 0;
  name_t            lead_name = '0;

  tally_t pending_tallies [$];
  int     mismatches = 0;
  int     stuck_cycles = 0;
  bit     calm = 1'b0;
  bit     hold_pending = 1'b0;

  // Carried beside the payload so the monitor knows which rows have a typed result.
  bit     row_typed;
  tally_t row_want;

  row_t   plan [DIR_ROWS];
  name_t  pool [POOL];
  int     pool_len [POOL];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // The name ends at its first zero byte; everything after it counts as zero.
  function automatic name_t trim_name(name_t raw);
    name_t nm;
    bit    ended;
    int    k;
    nm = raw;
    ended = 1'b0;
    for (k = 0; k < NAME_BYTES; k++) begin
      if (ended) begin
        nm[8*k +: 8] = 8'h00;
      end else if (nm[8*k +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return nm;
  endfunction

  function automatic tally_t tally_name(name_t raw);
    name_t  nm;
    int     hit;
    int     k;
    tally_t res;
    nm = trim_name(raw);
    hit = -1;
    res = '0;
    for (k = 0; k < tab_used; k++) begin
      if (hit < 0 && tab_name[k] == nm) hit = k;
    end
    if (hit >= 0) begin
      if (tab_count[hit] != CNT_MAX) tab_count[hit] = tab_count[hit] + 1'b1;
    end else if (tab_used < TABLE_DEPTH) begin
      hit = tab_used;
      tab_name[hit] = nm;
      tab_count[hit] = CNT_W'(1);
      tab_used++;
      res.was_new = 1'b1;
    end else begin
      res.table_full = 1'b1;
    end
    if (hit >= 0) begin
      res.count_for_name = tab_count[hit];
      // Ties go to the entry inserted first.
      if (tab_count[hit] > lead_count || (tab_count[hit] == lead_count && hit < lead_idx)) begin
        lead_count = tab_count[hit];
        lead_idx = hit;
        lead_name = nm;
      end
    end
    res.winner_count = lead_count;
    res.winner_low = lead_name[LOW_BITS-1:0];
    res.winner_mid = lead_name[LOW_BITS +: MID_BITS];
    res.winner_high = lead_name[NAME_BITS-1 -: HIGH_BITS];
    return res;
  endfunction

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 16);
  endfunction

  function automatic name_t make_name(int len);
    name_t nm;
    int    k;
    nm = '0;
    for (k = 0; k < len; k++) nm[8*k +: 8] = 8'($urandom_range(255, 1));
    return nm;
  endfunction

  task automatic offer_name(input name_t raw, input bit typed, input tally_t want);
    if (idle_roll()) begin
      names_ch.valid <= 1'b0;
      @(posedge clk);
      while (idle_roll()) @(posedge clk);
    end
    names_ch.valid <= 1'b1;
    names_ch.name_bytes_low <= raw[LOW_BITS-1:0];
    names_ch.name_bytes_mid <= raw[LOW_BITS +: MID_BITS];
    names_ch.name_bytes_high <= raw[NAME_BITS-1 -: HIGH_BITS];
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!names_ch.ready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    @(posedge clk);
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    tally_t got;
    tally_t want;
    if (!rst) begin
      if (results_ch.valid && results_ch.ready) begin
        got = '{results_ch.count_for_name, results_ch.was_new, results_ch.table_full,
                results_ch.winner_count, results_ch.winner_low, results_ch.winner_mid,
                results_ch.winner_high};
        if (pending_tallies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at %0t: count %0d top %0d", $realtime,
                     got.count_for_name, got.winner_count);
        end else begin
          want = pending_tallies.pop_front();
          if (got.count_for_name !== want.count_for_name || got.was_new !== want.was_new ||
              got.table_full !== want.table_full || got.winner_count !== want.winner_count ||
              got.winner_low !== want.winner_low || got.winner_mid !== want.winner_mid ||
              got.winner_high !== want.winner_high) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t (expected/actual): count %0d/%0d new %b/%b full %b/%b",
                       $realtime, want.count_for_name, got.count_for_name, want.was_new,
                       got.was_new, want.table_full, got.table_full);
              $display("  top %0d/%0d name %h/%h", want.winner_count, got.winner_count,
                       {want.winner_high, want.winner_mid, want.winner_low},
                       {got.winner_high, got.winner_mid, got.winner_low});
            end
          end
        end
      end
      if (names_ch.valid && names_ch.ready) begin
        want = tally_name({names_ch.name_bytes_high, names_ch.name_bytes_mid,
                           names_ch.name_bytes_low});
        pending_tallies.push_back(row_typed ? row_want : want);
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((names_ch.valid && names_ch.ready) || (results_ch.valid && results_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      results_ch.ready <= !idle_roll();
    end
  end

  initial begin
    int    i;
    int    n;
    int    pick;
    int    k;
    name_t nm;
    names_ch.valid <= 1'b0;
    names_ch.name_bytes_low <= '0;
    names_ch.name_bytes_mid <= '0;
    names_ch.name_bytes_high <= '0;
    row_typed <= 1'b0;
    row_want <= '0;

    // Empty name, junk after a terminator, a name with no zero byte, and ties.
    plan[0]  = '{{32'h0, 64'h0, 64'h0}, 1'b1,
                 '{16'd1, 1'b1, 1'b0, 16'd1, 64'h0, 64'h0, 32'h0}};
    plan[1]  = '{{32'h0, 64'h0, 64'hDEAD_BEEF_0000_0041}, 1'b1,
                 '{16'd1, 1'b1, 1'b0, 16'd1, 64'h0, 64'h0, 32'h0}};
    plan[2]  = '{{32'hFFFF_FFFF, ONES64, ONES64}, 1'b1,
                 '{16'd1, 1'b1, 1'b0, 16'd1, 64'h0, 64'h0, 32'h0}};
    plan[3]  = '{{32'h0, 64'h0, 64'h41}, 1'b1,
                 '{16'd2, 1'b0, 1'b0, 16'd2, 64'h41, 64'h0, 32'h0}};
    plan[4]  = '{{32'hFFFF_FFFF, ONES64, 64'hFFFF_FFFF_FFFF_FF00}, 1'b1,
                 '{16'd2, 1'b0, 1'b0, 16'd2, 64'h0, 64'h0, 32'h0}};
    plan[5]  = '{{32'hFFFF_FFFF, ONES64, ONES64}, 1'b0, '0};
    plan[6]  = '{{32'h1234_5678, 64'hFFFF_FF00_FFFF_FFFF, ONES64}, 1'b0, '0};
    plan[7]  = '{{32'hAB00_12FF, ONES64, ONES64}, 1'b0, '0};
    plan[8]  = '{{32'h00FF_FFFF, ONES64, ONES64}, 1'b0, '0};
    plan[9]  = '{{32'h0, ONES64, ONES64}, 1'b0, '0};
    plan[10] = '{{32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 64'h41}, 1'b0, '0};
    plan[11] = '{{32'h5555_5555, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0};
    plan[12] = '{{32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}, 1'b0, '0};
    plan[13] = '{{32'h0, 64'h0, 64'h8000_0000_0000_0001}, 1'b0, '0};
    plan[14] = '{{32'hFFFF_0000, 64'hFFFF_FF00_FFFF_FFFF, ONES64}, 1'b0, '0};
    plan[15] = '{{32'hFFFF_FFFF, ONES64, ONES64}, 1'b0, '0};
    plan[16] = '{{32'hFFFF_FFFF, ONES64, ONES64}, 1'b0, '0};

    @(posedge clk);
    while (rst) @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) offer_name(plan[i].raw, plan[i].typed, plan[i].want);

    // More distinct names than the table holds, so it fills and later new names drop.
    for (i = 0; i < POOL; i++) begin
      pool_len[i] = ($urandom_range(99) < 40) ? NAME_BYTES : $urandom_range(NAME_BYTES - 1, 0);
      pool[i] = make_name(pool_len[i]);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 700 && n < 800);
      if (n == 300) hold_pending = 1'b1;
      if (n == 600) begin
        names_ch.valid <= 1'b0;
        wait_all_results();
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        nm = {$urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
        i = (pick < 70) ? $urandom_range(29, 0) : $urandom_range(POOL - 1, 0);
        nm = pool[i];
        // Same name with garbage behind its terminator.
        if (pool_len[i] < NAME_BYTES && $urandom_range(3) == 0) begin
          for (k = pool_len[i] + 1; k < NAME_BYTES; k++) nm[8*k +: 8] = 8'($urandom_range(255, 0));
        end
      end
      offer_name(nm, 1'b0, '0);
    end

    names_ch.valid <= 1'b0;
    wait_all_results();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && pending_tallies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
